/* sv/gpsp_pkg.sv */
// ----------------------------------------------------------------------------
// gpsp_pkg : shared types and constants for the gamepad serial poll master
// Word types, byte-slot codes and command byte table used by the core, the
// result stage and the top level.
// ----------------------------------------------------------------------------
package gpsp_pkg;

   localparam int unsigned HALF_W          = 16;
   localparam logic [HALF_W-1:0] HALF_RESET = 16'd200;

   // reply byte slots (position within the 9-byte frame)
   localparam logic [3:0] BYTE_CMD_START  = 4'd0;
   localparam logic [3:0] BYTE_MODE       = 4'd1;
   localparam logic [3:0] BYTE_BTN_LO     = 4'd3;
   localparam logic [3:0] BYTE_BTN_HI     = 4'd4;
   localparam logic [3:0] BYTE_STICK_RX   = 4'd5;
   localparam logic [3:0] BYTE_STICK_RY   = 4'd6;
   localparam logic [3:0] BYTE_STICK_LX   = 4'd7;
   localparam logic [3:0] BYTE_LAST       = 4'd8;

   localparam logic [7:0] CMD_START       = 8'h01;
   localparam logic [7:0] CMD_POLL        = 8'h42;
   localparam logic [7:0] CMD_IDLE        = 8'h00;

   localparam logic [2:0] BIT_LAST        = 3'd7;

   typedef struct packed {
      logic start_poll;
      logic data_in_level;
   } req_word_type;

   typedef struct packed {
      logic        clock_level;
      logic        command_level;
      logic        select_level;
      logic        busy_res;
      logic        done_res;
      logic [7:0]  mode_id;
      logic [15:0] buttons;
      logic [7:0]  right_stick_x;
      logic [7:0]  right_stick_y;
      logic [7:0]  left_stick_x;
      logic [7:0]  left_stick_y;
   } rsp_word_type;

   function automatic logic [7:0] command_byte(input logic [3:0] pos);
      logic [7:0] val;
      unique case (pos)
         BYTE_CMD_START: val = CMD_START;
         BYTE_MODE:      val = CMD_POLL;
         default:        val = CMD_IDLE;
      endcase
      return val;
   endfunction

endpackage

/* sv/gpsp_if.sv */
// ----------------------------------------------------------------------------
// gpsp_if : request and response channels of the gamepad poll master
// Valid/ready channels carrying one sample word in and one pin/capture word out.
// ----------------------------------------------------------------------------
interface gpsp_req_if;
   logic valid;
   logic ready;
   logic start_poll;
   logic data_in_level;

   modport source (output valid, output start_poll, output data_in_level, input ready);
   modport sink   (input valid, input start_poll, input data_in_level, output ready);
endinterface

interface gpsp_rsp_if;
   logic        valid;
   logic        ready;
   logic        clock_level;
   logic        command_level;
   logic        select_level;
   logic        busy_res;
   logic        done_res;
   logic [7:0]  mode_id;
   logic [15:0] buttons;
   logic [7:0]  right_stick_x;
   logic [7:0]  right_stick_y;
   logic [7:0]  left_stick_x;
   logic [7:0]  left_stick_y;

   modport source (output valid, output clock_level, output command_level,
                   output select_level, output busy_res, output done_res,
                   output mode_id, output buttons, output right_stick_x,
                   output right_stick_y, output left_stick_x, output left_stick_y,
                   input ready);
   modport sink   (input valid, input clock_level, input command_level,
                   input select_level, input busy_res, input done_res,
                   input mode_id, input buttons, input right_stick_x,
                   input right_stick_y, input left_stick_x, input left_stick_y,
                   output ready);
endinterface

/* sv/gpsp_core.sv */
// ----------------------------------------------------------------------------
// gpsp_core : bit timer, frame sequencer and reply capture
// Advances one step per accepted word and forms that step's result word.
// ----------------------------------------------------------------------------
module gpsp_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  gpsp_pkg::req_word_type     req_word,
   input  logic [gpsp_pkg::HALF_W-1:0] half_period,
   output gpsp_pkg::rsp_word_type     rsp_word
);

   logic                        active_ff, active_in;
   logic [gpsp_pkg::HALF_W-1:0] count_ff, count_in;
   logic                        low_ff, low_in;
   logic [2:0]                  bit_ff, bit_in;
   logic [3:0]                  byte_ff, byte_in;
   logic [7:0]                  shift_ff, shift_in;
   logic [7:0]                  mode_ff, mode_in;
   logic [15:0]                 btn_ff, btn_in;
   logic [7:0]                  stick_ff [4];
   logic [7:0]                  stick_in [4];
   logic                        done;
   logic [7:0]                  shift_full;
   logic [gpsp_pkg::HALF_W:0]   count_inc;
   logic [1:0]                  stick_sel;
   logic [7:0]                  cmd_byte;

   always_comb begin
      active_in  = active_ff;
      count_in   = count_ff;
      low_in     = low_ff;
      bit_in     = bit_ff;
      byte_in    = byte_ff;
      shift_in   = shift_ff;
      mode_in    = mode_ff;
      btn_in     = btn_ff;
      stick_in   = stick_ff;
      done       = 1'b0;
      count_inc  = {1'b0, count_ff} + {{gpsp_pkg::HALF_W{1'b0}}, 1'b1};
      shift_full = shift_ff | (8'(req_word.data_in_level) << bit_ff);
      stick_sel  = byte_ff[1:0] - 2'd1;

      if (step) begin
         if (!active_ff) begin
            if (req_word.start_poll) begin
               active_in = 1'b1;
               count_in  = '0;
               low_in    = 1'b0;
               bit_in    = '0;
               byte_in   = '0;
               shift_in  = '0;
            end
         end else if (count_inc < {1'b0, half_period}) begin
            count_in = count_inc[gpsp_pkg::HALF_W-1:0];
         end else begin
            count_in = '0;
            if (!low_ff) begin
               low_in = 1'b1;
            end else begin
               low_in   = 1'b0;
               shift_in = shift_full;
               if (bit_ff == gpsp_pkg::BIT_LAST) begin
                  case (byte_ff)
                     gpsp_pkg::BYTE_MODE:   mode_in = shift_full;
                     gpsp_pkg::BYTE_BTN_LO: btn_in[7:0] = shift_full;
                     gpsp_pkg::BYTE_BTN_HI: btn_in[15:8] = shift_full;
                     gpsp_pkg::BYTE_STICK_RX, gpsp_pkg::BYTE_STICK_RY,
                     gpsp_pkg::BYTE_STICK_LX, gpsp_pkg::BYTE_LAST:
                        stick_in[stick_sel] = shift_full;
                     default: ;
                  endcase
                  shift_in = '0;
                  bit_in   = '0;
                  if (byte_ff >= gpsp_pkg::BYTE_LAST) begin
                     byte_in   = '0;
                     active_in = 1'b0;
                     done      = 1'b1;
                  end else begin
                     byte_in = byte_ff + 4'd1;
                  end
               end else begin
                  bit_in = bit_ff + 3'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
         low_ff    <= 1'b0;
         bit_ff    <= '0;
         byte_ff   <= '0;
         shift_ff  <= '0;
         mode_ff   <= '0;
         btn_ff    <= '1;
         stick_ff  <= '{default: '0};
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
         low_ff    <= low_in;
         bit_ff    <= bit_in;
         byte_ff   <= byte_in;
         shift_ff  <= shift_in;
         mode_ff   <= mode_in;
         btn_ff    <= btn_in;
         stick_ff  <= stick_in;
      end
   end

   // result reflects the state after this step
   assign cmd_byte = gpsp_pkg::command_byte(byte_in);

   always_comb begin
      rsp_word.clock_level   = active_in ? ~low_in : 1'b1;
      rsp_word.command_level = active_in ? cmd_byte[bit_in] : 1'b1;
      rsp_word.select_level  = ~active_in;
      rsp_word.busy_res      = active_in;
      rsp_word.done_res      = done;
      rsp_word.mode_id       = mode_in;
      rsp_word.buttons       = btn_in;
      rsp_word.right_stick_x = stick_in[0];
      rsp_word.right_stick_y = stick_in[1];
      rsp_word.left_stick_x  = stick_in[2];
      rsp_word.left_stick_y  = stick_in[3];
   end

endmodule

/* sv/gpsp_out_reg.sv */
// ----------------------------------------------------------------------------
// gpsp_out_reg : result register with valid/ready hand-off
// Holds one result word; refills in the same cycle the old one is taken.
// ----------------------------------------------------------------------------
module gpsp_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  gpsp_pkg::rsp_word_type word_in,
   input  logic                   take,
   output logic                   can_load,
   output logic                   valid,
   output gpsp_pkg::rsp_word_type word_out
);

   logic                   valid_ff, valid_in;
   gpsp_pkg::rsp_word_type word_ff;

   assign can_load = !valid_ff || take;
   assign valid_in = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign valid    = valid_ff;
   assign word_out = word_ff;

endmodule

/* sv/gamepad_serial_poll_master_unit.sv */
// ----------------------------------------------------------------------------
// gamepad_serial_poll_master_unit : gamepad serial poll master, stepped form
// Top level: half-period register, sequencer core and result register.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan carries one sample word per step: start_poll and the level of
//    the controller data line. Each accepted word advances the poll by one
//    step of the bit timer.
//  - rsp_chan returns exactly one word per accepted request: the pin levels
//    (clock, command, select), busy/done and the captured reply bytes, all
//    as they stand after that step.
//  - csr_we/csr_wdata write the half-period length in steps (0 acts as 1).
//    Write it only while idle.
//  - rsp valid rises in the cycle after accept; one word per cycle while
//    rsp is not stalled. Core logic between the step registers and the
//    result register is one 17-bit compare plus byte selection.
//  - When rsp is stalled the result register holds its word and req_ready
//    drops; it rises again in the cycle the held word is taken, so no
//    bubble is inserted.
//  - Reset (synchronous, high) idles the poll, empties the result register,
//    sets buttons to all ones (nothing pressed) and the half period to 200.
// ----------------------------------------------------------------------------
module gamepad_serial_poll_master_unit (
   input  logic                        clock,
   input  logic                        reset,
   gpsp_req_if.sink                    req_chan,
   gpsp_rsp_if.source                  rsp_chan,
   input  logic                        csr_we,
   input  logic [gpsp_pkg::HALF_W-1:0] csr_wdata
);

   logic [gpsp_pkg::HALF_W-1:0] half_ff;
   logic                        req_accept;
   logic                        can_load;
   gpsp_pkg::req_word_type      req_word;
   gpsp_pkg::rsp_word_type      step_word;
   gpsp_pkg::rsp_word_type      out_word;
   logic                        out_valid;

   // half-period config register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= gpsp_pkg::HALF_RESET;
      end else if (csr_we) begin
         half_ff <= csr_wdata;
      end
   end

   // accept whenever the result register is free or being drained
   assign req_chan.ready = can_load;
   assign req_accept     = req_chan.valid && can_load;

   assign req_word.start_poll    = req_chan.start_poll;
   assign req_word.data_in_level = req_chan.data_in_level;

   gpsp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (req_accept),
      .req_word    (req_word),
      .half_period (half_ff),
      .rsp_word    (step_word)
   );

   gpsp_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (req_accept),
      .word_in  (step_word),
      .take     (rsp_chan.ready),
      .can_load (can_load),
      .valid    (out_valid),
      .word_out (out_word)
   );

   assign rsp_chan.valid         = out_valid;
   assign rsp_chan.clock_level   = out_word.clock_level;
   assign rsp_chan.command_level = out_word.command_level;
   assign rsp_chan.select_level  = out_word.select_level;
   assign rsp_chan.busy_res      = out_word.busy_res;
   assign rsp_chan.done_res      = out_word.done_res;
   assign rsp_chan.mode_id       = out_word.mode_id;
   assign rsp_chan.buttons       = out_word.buttons;
   assign rsp_chan.right_stick_x = out_word.right_stick_x;
   assign rsp_chan.right_stick_y = out_word.right_stick_y;
   assign rsp_chan.left_stick_x  = out_word.left_stick_x;
   assign rsp_chan.left_stick_y  = out_word.left_stick_y;

`ifndef ASSERT_OFF
   // every accepted request yields a result word in the next cycle
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_chan.valid)
      else $error("accepted request produced no result word");

   // the poll-complete word already shows the bus released
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.done_res) |->
         (!rsp_chan.busy_res && rsp_chan.select_level))
      else $error("done reported while still busy");

   // select is low exactly while busy
   a_select_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.select_level != rsp_chan.busy_res))
      else $error("select and busy disagree");

   // idle bus: clock and command parked high
   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.busy_res) |->
         (rsp_chan.clock_level && rsp_chan.command_level))
      else $error("idle bus not parked high");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb : testbench for the gamepad serial poll master unit
// Sends sample words (start request and data line level) to the unit, steps
// a cycle-level model of the poll sequencer for every accepted word and checks
// each response word field by field, in order. The half period is changed
// between phases, and the sender and receiver idle at varying rates.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned LONG_HOLD    = 80;
   localparam int unsigned HOLD_LEAD_IN = 40;

   // how the fake controller drives its data line over a stretch of words
   typedef enum logic [1:0] {LINE_NOISE, LINE_LOW, LINE_HIGH} line_style_type;

   // -------------------------------------------------------------------------
   // Poll scoreboard: own copy of the sequencer state, steps it once per
   // accepted sample word and queues the response word it should produce.
   // -------------------------------------------------------------------------
   class poll_scoreboard;
      logic [15:0]            half_period;
      logic                   poll_active;
      logic [15:0]            step_count;
      logic                   in_low_phase;
      logic [2:0]             bit_idx;
      logic [3:0]             byte_idx;
      logic [7:0]             rx_shift;
      logic [7:0]             mode_byte;
      logic [15:0]            button_word;
      logic [7:0]             stick_byte [4];
      gpsp_pkg::rsp_word_type expected_words [$];
      int unsigned            errors;
      int unsigned            checked;

      function new();
         half_period  = gpsp_pkg::HALF_RESET;
         poll_active  = 1'b0;
         step_count   = '0;
         in_low_phase = 1'b0;
         bit_idx      = '0;
         byte_idx     = '0;
         rx_shift     = '0;
         mode_byte    = '0;
         button_word  = 16'hFFFF;
         foreach (stick_byte[i]) stick_byte[i] = '0;
         errors       = 0;
         checked      = 0;
      endfunction

      function void set_half(logic [15:0] value);
         half_period = value;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // a finished reply byte lands in its capture slot right away
      function void store_reply(logic [3:0] pos, logic [7:0] value);
         case (pos)
            gpsp_pkg::BYTE_MODE:   mode_byte = value;
            gpsp_pkg::BYTE_BTN_LO: button_word[7:0] = value;
            gpsp_pkg::BYTE_BTN_HI: button_word[15:8] = value;
            default: begin
               if (pos >= gpsp_pkg::BYTE_STICK_RX && pos <= gpsp_pkg::BYTE_LAST)
                  stick_byte[2'(pos - gpsp_pkg::BYTE_STICK_RX)] = value;
            end
         endcase
      endfunction

      function gpsp_pkg::rsp_word_type step_poll(logic start, logic din);
         gpsp_pkg::rsp_word_type w;
         logic                   done;
         logic [7:0]             tx_byte;
         done = 1'b0;
         if (!poll_active) begin
            if (start) begin
               poll_active  = 1'b1;
               step_count   = '0;
               in_low_phase = 1'b0;
               bit_idx      = '0;
               byte_idx     = '0;
               rx_shift     = '0;
            end
         end else if (({1'b0, step_count} + 17'd1) < {1'b0, half_period}) begin
            step_count = step_count + 16'd1;
         end else begin
            step_count = '0;
            if (!in_low_phase) begin
               in_low_phase = 1'b1;
            end else begin
               // end of the low phase: sample the data line
               in_low_phase = 1'b0;
               rx_shift = rx_shift | (8'(din) << bit_idx);
               if (bit_idx == gpsp_pkg::BIT_LAST) begin
                  store_reply(byte_idx, rx_shift);
                  rx_shift = '0;
                  bit_idx  = '0;
                  if (byte_idx >= gpsp_pkg::BYTE_LAST) begin
                     byte_idx    = '0;
                     poll_active = 1'b0;
                     done        = 1'b1;
                  end else begin
                     byte_idx = byte_idx + 4'd1;
                  end
               end else begin
                  bit_idx = bit_idx + 3'd1;
               end
            end
         end
         if (byte_idx == gpsp_pkg::BYTE_CMD_START)
            tx_byte = gpsp_pkg::CMD_START;
         else if (byte_idx == gpsp_pkg::BYTE_MODE)
            tx_byte = gpsp_pkg::CMD_POLL;
         else
            tx_byte = gpsp_pkg::CMD_IDLE;
         w.clock_level   = poll_active ? ~in_low_phase : 1'b1;
         w.command_level = poll_active ? tx_byte[bit_idx] : 1'b1;
         w.select_level  = ~poll_active;
         w.busy_res      = poll_active;
         w.done_res      = done;
         w.mode_id       = mode_byte;
         w.buttons       = button_word;
         w.right_stick_x = stick_byte[0];
         w.right_stick_y = stick_byte[1];
         w.left_stick_x  = stick_byte[2];
         w.left_stick_y  = stick_byte[3];
         return w;
      endfunction

      function void note_request(logic start, logic din);
         expected_words.push_back(step_poll(start, din));
      endfunction

      task report(string msg);
         $display("tb: error: %s", msg);
         errors++;
      endtask

      task check_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report($sformatf("word %0d %s: got %h, want %h", checked, name, got, want));
      endtask

      task check_response(gpsp_pkg::rsp_word_type got);
         gpsp_pkg::rsp_word_type want;
         if (expected_words.size() == 0) begin
            report($sformatf("word %0d arrived with nothing expected", checked));
            checked++;
            return;
         end
         want = expected_words.pop_front();
         check_field("clock_level",   got.clock_level,   want.clock_level);
         check_field("command_level", got.command_level, want.command_level);
         check_field("select_level",  got.select_level,  want.select_level);
         check_field("busy_res",      got.busy_res,      want.busy_res);
         check_field("done_res",      got.done_res,      want.done_res);
         check_field("mode_id",       got.mode_id,       want.mode_id);
         check_field("buttons",       got.buttons,       want.buttons);
         check_field("right_stick_x", got.right_stick_x, want.right_stick_x);
         check_field("right_stick_y", got.right_stick_y, want.right_stick_y);
         check_field("left_stick_x",  got.left_stick_x,  want.left_stick_x);
         check_field("left_stick_y",  got.left_stick_y,  want.left_stick_y);
         checked++;
      endtask

      task check_leftover();
         if (expected_words.size() != 0)
            report($sformatf("%0d expected words never arrived", expected_words.size()));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the unit under test
   // -------------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [15:0] csr_wdata;

   gpsp_req_if req_chan ();
   gpsp_rsp_if rsp_chan ();

   gamepad_serial_poll_master_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   poll_scoreboard sb;

   // idling knobs; the receiver's knobs only change right after a rising edge
   int unsigned    send_idle_pct;
   int unsigned    recv_stall_pct;
   int unsigned    hold_token;
   line_style_type line_style;

   // receiver-owned state for the long hold-off
   int unsigned hold_served;
   int unsigned hold_left;
   int unsigned lead_in;

   int unsigned cycle_count;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Watchdog: a hang anywhere (drain wait, stuck ready) ends here.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random stalls at recv_stall_pct. Each new hold_token asks for
   // one long hold-off, taken after a short lead-in so the unit is busy when
   // it starts; the sender keeps offering words meanwhile and the unit has to
   // back-pressure its input.
   // -------------------------------------------------------------------------
   initial begin
      hold_served = 0;
      hold_left   = 0;
      lead_in     = 0;
   end

   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready = 1'b0;
      end else begin
         if (hold_token != hold_served) begin
            if (lead_in < HOLD_LEAD_IN) begin
               lead_in++;
            end else begin
               hold_served = hold_token;
               hold_left   = LONG_HOLD;
               lead_in     = 0;
            end
         end
         rsp_chan.ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: handshakes are sampled at the rising edge. Every accepted sample
   // word steps the model; every accepted response word is checked.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      gpsp_pkg::rsp_word_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_request(req_chan.start_poll, req_chan.data_in_level);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.clock_level   = rsp_chan.clock_level;
            got.command_level = rsp_chan.command_level;
            got.select_level  = rsp_chan.select_level;
            got.busy_res      = rsp_chan.busy_res;
            got.done_res      = rsp_chan.done_res;
            got.mode_id       = rsp_chan.mode_id;
            got.buttons       = rsp_chan.buttons;
            got.right_stick_x = rsp_chan.right_stick_x;
            got.right_stick_y = rsp_chan.right_stick_y;
            got.left_stick_x  = rsp_chan.left_stick_x;
            got.left_stick_y  = rsp_chan.left_stick_y;
            sb.check_response(got);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender side
   // -------------------------------------------------------------------------

   // Data line level: stretches of noise, all low or all high, long enough that whole
   // reply bytes of all zeros and all ones show up.
   function automatic logic next_level();
      if ($urandom_range(63) == 0)
         line_style = line_style_type'($urandom_range(2));
      case (line_style)
         LINE_LOW:  return 1'b0;
         LINE_HIGH: return 1'b1;
         default:   return 1'($urandom_range(1));
      endcase
   endfunction

   // One sample word; inputs change on the falling edge only.
   task automatic send_sample(input logic start, input logic din);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid         = 1'b0;
         req_chan.start_poll    = 1'($urandom_range(1));
         req_chan.data_in_level = 1'($urandom_range(1));
         @(negedge clock);
      end
      req_chan.valid         = 1'b1;
      req_chan.start_poll    = start;
      req_chan.data_in_level = din;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   // Sender pause: nothing goes in until every expected word has come back.
   task automatic wait_drained();
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Half-period write, only with the pipeline empty.
   task automatic write_half(input logic [15:0] value);
      wait_drained();
      repeat (2) @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = value;
      @(posedge clock);
      sb.set_half(value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Random phase. Start is high half the time, so new polls begin right
   // after one ends and requests also land on busy steps and on done steps.
   task automatic run_phase(input logic [15:0] half, input int unsigned idle_pct,
                            input int unsigned stall_pct, input int unsigned n_words,
                            input bit long_hold);
      write_half(half);
      @(posedge clock);
      recv_stall_pct = stall_pct;
      if (long_hold)
         hold_token++;
      send_idle_pct = idle_pct;
      @(negedge clock);
      repeat (n_words) send_sample(1'($urandom_range(1)), next_level());
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_wdata              = '0;
      req_chan.valid         = 1'b0;
      req_chan.start_poll    = 1'b0;
      req_chan.data_in_level = 1'b0;
      rsp_chan.ready         = 1'b0;
      send_idle_pct          = 0;
      recv_stall_pct         = 0;
      hold_token             = 0;
      line_style             = LINE_NOISE;
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset half period, idle word, start, start while busy
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b0);
      // longest half period, mid-poll
      write_half(16'hFFFF);
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b0);
      // shortest half period: count already past it, phase ends next step
      write_half(16'd1);
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b0);
      send_sample(1'b1, 1'b1);
      send_sample(1'b1, 1'b0);
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b0);
      send_sample(1'b1, 1'b1);
      // zero half period acts like one
      write_half(16'd0);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b1);
      send_sample(1'b0, 1'b0);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);

      // random: no idling plus one long receiver hold-off, then sender gaps,
      // then receiver stalls, then both
      run_phase(16'd1,  0,  0, 190, 1'b1);
      run_phase(16'd0, 66,  0, 190, 1'b0);
      run_phase(16'd2,  0, 66, 190, 1'b0);
      run_phase(16'd1, 22, 22, 190, 1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.check_leftover();
      if (sb.errors == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
